FILE: hdl/lsh_pkg.sv
// ----------------------------------------------------------------------------
// lsh_pkg
// Shared constants, register codes and the quarter-wave sine table for the
// smoothed Heaviside level-set kernel.
// ----------------------------------------------------------------------------
package lsh_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int SINE_DEPTH  = 256;
  localparam int ONE_W       = FRAC_BITS + 1;         // holds 0..ONE
  localparam int SIN_W       = FRAC_BITS + 2;         // signed -ONE..ONE
  localparam int IDX_W       = $clog2(SINE_DEPTH + 1);
  localparam int LUT_LG      = $clog2(2 * SINE_DEPTH);
  localparam int LUT_SH      = FRAC_BITS - LUT_LG;    // fraction bits below index

  localparam logic [ONE_W-1:0] ONE_Q  = ONE_W'(1) << FRAC_BITS;
  localparam logic [ONE_W-1:0] HALF_Q = ONE_W'(1) << (FRAC_BITS - 1);
  localparam logic [ONE_W-1:0] LIQUID_MIN = ONE_W'((4 * (1 << FRAC_BITS) + 4) / 5);

  localparam logic [30:0] PI_HALF_Q30  = 31'd1686629713;
  localparam logic [29:0] INV_PI_Q30   = 30'd341782638;
  localparam logic [25:0] INV_4PI2_Q30 = 26'd27198198;

  // configuration register indexes
  localparam logic [1:0] REG_EPSILON     = 2'd0;
  localparam logic [1:0] REG_INV_EPSILON = 2'd1;
  localparam logic [1:0] REG_GAMMA       = 2'd2;

  localparam logic [30:0] EPSILON_RST     = 31'd65536;
  localparam logic [31:0] INV_EPSILON_RST = 32'd65536;
  localparam logic [30:0] GAMMA_RST       = 31'd49152;

  typedef logic [ONE_W-1:0] sine_rom_t [0:SINE_DEPTH];

  // sin(pi/2 * k/DEPTH): Q30 Taylor series, rounded to the fraction width
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    for (int k = 0; k <= SINE_DEPTH; k++) begin
      a    = (64'(PI_HALF_Q30) * 64'(k) + 64'(SINE_DEPTH / 2)) / 64'(SINE_DEPTH);
      a2   = (a * a) >> 30;
      term = a;
      sum  = $signed(a);
      for (int n = 1; n <= 12; n++) begin
        term = ((term * a2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) sum = sum - $signed(term);
        else            sum = sum + $signed(term);
      end
      if (sum < 0) sum = 0;
      v = $signed((64'(sum) + (64'(1) << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
      if (v > $signed(64'(ONE_Q))) v = $signed(64'(ONE_Q));
      rom[k] = ONE_W'(v);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

FILE: hdl/level_set_smoothed_heaviside.sv
// ----------------------------------------------------------------------------
// level_set_smoothed_heaviside
// Per-cell smoothed Heaviside / Dirac delta kernel with saturating outputs.
// ----------------------------------------------------------------------------
// One cell enters per clock and leaves through the output register; the
// nine register stages (range, distance scaling, angle forming, two table
// stages, products, sums, final product, saturation) all advance together
// while the output register is empty or being taken, so throughput is one
// request per cycle with no stall from the data. s_axis_tready drops only
// while a finished result waits on m_axis_tready. sin and cos come from a
// 257-entry quarter-wave table with linear interpolation, three lookups per
// cell. The user must write epsilon, inv_epsilon and gamma through the cfg
// port only while no cell is in flight, which is not enforced; inv_epsilon
// must be the reciprocal of epsilon, and x is clamped to [-1, 1] if inexact.
module level_set_smoothed_heaviside import lsh_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [55:0]  s_axis_tdata,   // psi[31:0], alpha[48:32], zero pad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata    // delta, heaviside, heaviside_scaled,
                                       // delta_scale, initial_level,
                                       // liquid_flag, zero pad
);

  localparam int NSTG = 9;

  logic [30:0] eps_q;
  logic [31:0] inv_eps_q;
  logic [30:0] gamma_q;
  logic [NSTG-1:0] vld_q;
  logic en;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q     <= EPSILON_RST;
      inv_eps_q <= INV_EPSILON_RST;
      gamma_q   <= GAMMA_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_EPSILON:     eps_q     <= cfg_data_i[30:0];
        REG_INV_EPSILON: inv_eps_q <= cfg_data_i;
        REG_GAMMA:       gamma_q   <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // whole pipe advances unless a result is held at the output
  assign en            = !vld_q[NSTG-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[NSTG-2:0], s_axis_tvalid};
  end

  // stage 1: magnitude and band test
  logic signed [31:0] psi_in;
  logic [31:0] mag_d, mag_q1;
  logic        sgn_q1, band_q1;
  logic [ONE_W-1:0] alpha_q1;

  assign psi_in = $signed(s_axis_tdata[31:0]);
  assign mag_d  = psi_in[31] ? 32'(-psi_in) : 32'(psi_in);

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q1   <= mag_d;
      sgn_q1   <= psi_in[31];
      band_q1  <= mag_d <= {1'b0, eps_q};
      alpha_q1 <= s_axis_tdata[48:32];
    end
  end

  // stage 2: scale the distance, form the initial level product
  logic signed [20:0] il_fac;
  logic [63:0] xp_q2;
  logic signed [52:0] ilp_q2;
  logic sgn_q2, band_q2, flag_q2;

  assign il_fac = $signed(21'(alpha_q1) * 21'd5) - $signed(21'(ONE_Q) << 2);

  always_ff @(posedge clk_i) begin
    if (en) begin
      xp_q2   <= 64'(mag_q1) * 64'(inv_eps_q);
      ilp_q2  <= il_fac * $signed({1'b0, gamma_q});
      sgn_q2  <= sgn_q1;
      band_q2 <= band_q1;
      flag_q2 <= alpha_q1 >= LIQUID_MIN;
    end
  end

  // stage 3: clamp x, saturate initial level
  logic [47:0] xm_raw;
  logic [ONE_W-1:0] xm;
  logic signed [SIN_W-1:0] x_q3;
  logic signed [36:0] il_s;
  logic signed [31:0] il_d, il_q3;
  logic sgn_q3, band_q3, flag_q3;

  always_comb begin
    xm_raw = xp_q2[63:FRAC_BITS];
    xm     = (xm_raw > 48'(ONE_Q)) ? ONE_Q : xm_raw[ONE_W-1:0];
    il_s   = 37'(ilp_q2 >>> FRAC_BITS);
    if (il_s > 37'sd2147483647)       il_d = 32'sh7FFFFFFF;
    else if (il_s < -37'sd2147483648) il_d = 32'sh80000000;
    else                              il_d = il_s[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q3    <= sgn_q2 ? -$signed({1'b0, xm}) : $signed({1'b0, xm});
      il_q3   <= il_d;
      sgn_q3  <= sgn_q2;
      band_q3 <= band_q2;
      flag_q3 <= flag_q2;
    end
  end

  // stages 4 and 5: sin(pi x), cos(pi x), cos(2 pi x)
  logic [ONE_W-1:0] u_s, u_c, u_c2;
  logic signed [SIN_W-1:0] s_v, c_v, c2_v;

  assign u_s  = x_q3[ONE_W-1:0];
  assign u_c  = x_q3[ONE_W-1:0] + HALF_Q;
  assign u_c2 = {x_q3[ONE_W-2:0], 1'b0} + HALF_Q;

  lsh_sin_lut u_sin  (.clk_i, .en_i(en), .u_i(u_s),  .val_o(s_v));
  lsh_sin_lut u_cos  (.clk_i, .en_i(en), .u_i(u_c),  .val_o(c_v));
  lsh_sin_lut u_cos2 (.clk_i, .en_i(en), .u_i(u_c2), .val_o(c2_v));

  // carry side data alongside the table stages
  logic signed [SIN_W-1:0] x_q4, x_q5;
  logic signed [35:0] xx_q4, xx_q5;
  logic signed [31:0] il_q4, il_q5;
  logic sgn_q4, sgn_q5, band_q4, band_q5, flag_q4, flag_q5;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q4 <= x_q3;   xx_q4 <= x_q3 * x_q3; il_q4 <= il_q3;
      sgn_q4 <= sgn_q3; band_q4 <= band_q3; flag_q4 <= flag_q3;
      x_q5 <= x_q4;   xx_q5 <= xx_q4;       il_q5 <= il_q4;
      sgn_q5 <= sgn_q4; band_q5 <= band_q4; flag_q5 <= flag_q4;
    end
  end

  // stage 6: products of the trig terms
  logic [ONE_W:0] oc;
  logic signed [ONE_W+1:0] opx;
  logic [49:0] pd_q6;
  logic signed [48:0] ph_q6;
  logic signed [45:0] pc2_q6;
  logic signed [36:0] psx_q6;
  logic signed [SIN_W-1:0] x_q6;
  logic signed [35:0] xx_q6;
  logic signed [31:0] il_q6;
  logic sgn_q6, band_q6, flag_q6;

  assign oc  = (ONE_W+1)'($signed({2'b0, ONE_Q}) + c_v);
  assign opx = $signed({2'b0, ONE_Q}) + x_q5;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pd_q6  <= 50'(oc) * 50'(inv_eps_q);
      ph_q6  <= s_v * $signed({1'b0, INV_PI_Q30});
      pc2_q6 <= ($signed({c2_v[SIN_W-1], c2_v}) - $signed({2'b0, ONE_Q}))
                * $signed({1'b0, INV_4PI2_Q30});
      psx_q6 <= s_v * opx;
      x_q6 <= x_q5; xx_q6 <= xx_q5; il_q6 <= il_q5;
      sgn_q6 <= sgn_q5; band_q6 <= band_q5; flag_q6 <= flag_q5;
    end
  end

  // stage 7: delta, heaviside, partial sum of the scaled variant
  logic [32:0] dl_raw;
  logic signed [21:0] h_sum, h_half;
  logic [ONE_W-1:0] h_d, h_q7;
  logic [31:0] dl_q7;
  logic signed [51:0] phs_q7;
  logic signed [23:0] acc_d, acc_q7;
  logic signed [31:0] il_q7;
  logic sgn_q7, band_q7, flag_q7;

  always_comb begin
    dl_raw = pd_q6[49:FRAC_BITS+1];
    h_sum  = $signed({4'b0, ONE_Q}) + 22'(x_q6) + 22'(ph_q6 >>> 30);
    h_half = h_sum >>> 1;
    if (h_half < 0)                         h_d = '0;
    else if (h_half > $signed({4'b0, ONE_Q})) h_d = ONE_Q;
    else                                    h_d = h_half[ONE_W-1:0];
    acc_d = $signed({6'b0, HALF_Q}) + 24'(x_q6) + 24'(xx_q6 >>> (FRAC_BITS + 1))
          - 24'(pc2_q6 >>> 30);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dl_q7  <= dl_raw[32] ? 32'hFFFFFFFF : dl_raw[31:0];
      h_q7   <= h_d;
      phs_q7 <= 21'(psx_q6 >>> FRAC_BITS) * $signed({1'b0, INV_PI_Q30});
      acc_q7 <= acc_d;
      il_q7 <= il_q6; sgn_q7 <= sgn_q6; band_q7 <= band_q6; flag_q7 <= flag_q6;
    end
  end

  // stage 8: scaled heaviside, band select, final product
  logic signed [24:0] hs_sum, hs_half;
  logic [ONE_W-1:0] hs_d, hsel, hssel, h_q8, hs_q8;
  logic [31:0] dsel, dl_q8;
  logic [48:0] ds_q8;
  logic signed [31:0] il_q8;
  logic flag_q8;

  always_comb begin
    hs_sum  = 25'(acc_q7) + 25'(phs_q7 >>> 30);
    hs_half = hs_sum >>> 1;
    if (hs_half < 0)                           hs_d = '0;
    else if (hs_half > $signed({8'b0, ONE_Q}))  hs_d = ONE_Q;
    else                                       hs_d = hs_half[ONE_W-1:0];
    if (band_q7) begin
      hsel = h_q7; hssel = hs_d; dsel = dl_q7;
    end else begin
      hsel  = sgn_q7 ? '0 : ONE_Q;
      hssel = hsel;
      dsel  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_q8  <= hsel;
      hs_q8 <= hssel;
      dl_q8 <= dsel;
      ds_q8 <= 49'(hsel) * 49'(dsel);
      il_q8 <= il_q7;
      flag_q8 <= flag_q7;
    end
  end

  // stage 9: saturate delta_scale, hold the result for the consumer
  logic [33:0] ds_raw;
  logic [32:0] ds_sat;
  logic [135:0] out_q;

  assign ds_raw = ds_q8[48:FRAC_BITS-1];
  assign ds_sat = ds_raw[33] ? 33'h1FFFFFFFF : ds_raw[32:0];

  always_ff @(posedge clk_i) begin
    if (en) out_q <= {4'b0, flag_q8, il_q8, ds_sat, hs_q8, h_q8, dl_q8};
  end

  assign m_axis_tdata = out_q;

endmodule

FILE: hdl/lsh_sin_lut.sv
// ----------------------------------------------------------------------------
// lsh_sin_lut
// Two-stage sin(pi*u) lookup: fold onto the quarter wave, then read the table
// and interpolate linearly.
// ----------------------------------------------------------------------------
module lsh_sin_lut import lsh_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [ONE_W-1:0]        u_i,    // angle in units of pi, modulo 2
  output logic signed [SIN_W-1:0] val_o
);

  logic [ONE_W-1:0]  w;
  logic [IDX_W-1:0]  idx_d, idx_q, idx1;
  logic [FRAC_BITS-1:0] fr_d, fr_q;
  logic              neg_q, neg2_q;
  logic [ONE_W-1:0]  r0, r1, base_q;
  logic signed [ONE_W:0]        diff;
  logic signed [ONE_W+FRAC_BITS+1:0] prod_d, prod_q;
  logic signed [SIN_W:0]        mag;

  // fold second quadrant onto the first
  always_comb begin
    w = {1'b0, u_i[FRAC_BITS-1:0]};
    if (w > HALF_Q) w = ONE_Q - w;
    idx_d = IDX_W'(w >> LUT_SH);
    fr_d  = {w[LUT_SH-1:0], {LUT_LG{1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      idx_q <= idx_d;
      fr_q  <= fr_d;
      neg_q <= u_i[FRAC_BITS];
    end
  end

  always_comb begin
    idx1   = (idx_q == IDX_W'(SINE_DEPTH)) ? idx_q : idx_q + IDX_W'(1);
    r0     = SINE_ROM[idx_q];
    r1     = SINE_ROM[idx1];
    diff   = $signed({1'b0, r1}) - $signed({1'b0, r0});
    prod_d = diff * $signed({1'b0, fr_q});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      base_q <= r0;
      prod_q <= prod_d;
      neg2_q <= neg_q;
    end
  end

  always_comb begin
    mag   = $signed({2'b00, base_q}) + (SIN_W+1)'(prod_q >>> FRAC_BITS);
    val_o = SIN_W'(neg2_q ? -mag : mag);
  end

endmodule

FILE: hdl/lsh_chk.sv
// ----------------------------------------------------------------------------
// lsh_chk
// Port-level checks for the smoothed Heaviside kernel.
// ----------------------------------------------------------------------------
module lsh_chk (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [135:0] m_axis_tdata
);

  // a held result holds its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  // a stalled output stops intake
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("request taken while output stalled");

  // heaviside stays in [0, 1]
  a_h: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[48:32] <= 17'd65536)
    else $error("heaviside out of range");

  a_hs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[65:49] <= 17'd65536)
    else $error("scaled heaviside out of range");

endmodule

bind level_set_smoothed_heaviside lsh_chk u_lsh_chk (.*);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the smoothed Heaviside level-set kernel. It drives
// psi/alpha requests through the input stream and predicts every result in
// the bench from scratch: its own sine table, fold and interpolation. It
// checks each result field by field and sweeps the three registers through
// their extremes. Both sides of the stream idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import lsh_pkg::*;

  localparam int  DRAIN_CYCLES = 20;     // pipeline is nine deep; leave margin
  localparam int  ALPHA_LIQUID = 52429;  // ceil(0.8 * 2^16)
  localparam longint ONE_L     = 65536;
  localparam longint INV_PI_L  = 341782638;
  localparam longint INV_4PI2_L = 27198198;

  typedef struct packed {
    logic        liquid_flag;
    logic [31:0] initial_level;
    logic [32:0] delta_scale;
    logic [16:0] heaviside_scaled;
    logic [16:0] heaviside;
    logic [31:0] delta;
  } cell_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_idx_i = REG_EPSILON;
  logic [31:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [55:0]  s_axis_tdata = '0;   // psi[31:0], alpha[48:32], zero pad
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;        // delta, heaviside, heaviside_scaled,
                                     // delta_scale, initial_level, flag, pad

  level_set_smoothed_heaviside u_dut (.*);

  initial forever #6 clk_i = ~clk_i;

  // bench copy of the registers and the quarter-wave sine table
  logic [63:0]   eps_q   = 64'd65536;
  logic [63:0]   inv_q   = 64'd65536;
  logic [63:0]   gamma_q = 64'd49152;
  longint        quarter_sine [0:256];
  cell_result_t  pending_results [$];
  bit            steady = 1'b0;      // no idling on either side while set
  int            errors = 0;
  int            cells_sent = 0;
  int            results_checked = 0;
  int            band_cells = 0;
  int            config_sets = 0;

  // sin(pi/2 * k/256) from a Q30 Taylor series, rounded to 16 fraction bits
  function automatic void fill_sine_table();
    logic [63:0] ang, ang2, term;
    longint      acc, v;
    for (int k = 0; k <= 256; k++) begin
      ang  = (64'd1686629713 * 64'(k) + 64'd128) / 64'd256;
      ang2 = (ang * ang) >> 30;
      term = ang;
      acc  = longint'(ang);
      for (int n = 1; n <= 12; n++) begin
        term = ((term * ang2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) acc -= longint'(term);
        else            acc += longint'(term);
      end
      if (acc < 0) acc = 0;
      v = longint'((64'(acc) + (64'd1 << 13)) >> 14);
      if (v > ONE_L) v = ONE_L;
      quarter_sine[k] = v;
    end
  endfunction

  // sin(pi*u), u in units of pi with 16 fraction bits, taken modulo 2
  function automatic longint sine_of_turn(logic [63:0] u);
    logic        neg;
    logic [63:0] t, idx;
    longint      fr, v;
    u   = u & 64'h1FFFF;
    neg = u >= 64'd65536;
    if (neg) u -= 64'd65536;
    if (u > 64'd32768) u = 64'd65536 - u;
    t   = u * 64'd512;
    idx = t >> 16;
    fr  = longint'(t & 64'hFFFF);
    if (idx >= 64'd256) v = quarter_sine[256];
    else v = quarter_sine[idx] + (((quarter_sine[idx + 1] - quarter_sine[idx]) * fr) >>> 16);
    return neg ? -v : v;
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v < 0) return 0;
    if (v > ONE_L) return ONE_L;
    return v;
  endfunction

  function automatic cell_result_t predict_cell(logic [31:0] psi, logic [16:0] alpha);
    cell_result_t r;
    longint       ps, x, s, c, c2, oc, h, hs, acc, il;
    logic [63:0]  mag, xm, ux, dl, ds;
    ps  = longint'($signed(psi));
    mag = ps < 0 ? 64'(-ps) : 64'(ps);
    if (mag > eps_q) begin
      dl = 0;
      h  = ps < 0 ? 0 : ONE_L;
      hs = h;
    end else begin
      xm = (mag * inv_q) >> 16;
      if (xm > 64'd65536) xm = 64'd65536;
      x  = ps < 0 ? -longint'(xm) : longint'(xm);
      ux = 64'(x);
      s  = sine_of_turn(ux);
      c  = sine_of_turn(ux + 64'd32768);
      c2 = sine_of_turn(ux * 2 + 64'd32768);
      oc = ONE_L + c;
      if (oc < 0) oc = 0;
      dl = (64'(oc) * inv_q) >> 17;
      if (dl > 64'hFFFF_FFFF) dl = 64'hFFFF_FFFF;
      h   = clamp_unit((ONE_L + x + ((s * INV_PI_L) >>> 30)) >>> 1);
      acc = ONE_L / 2 + x + ((x * x) >>> 17) - (((c2 - ONE_L) * INV_4PI2_L) >>> 30)
            + ((((s * (ONE_L + x)) >>> 16) * INV_PI_L) >>> 30);
      hs  = clamp_unit(acc >>> 1);
    end
    ds = (64'(h) * dl) >> 15;
    if (ds > 64'h1_FFFF_FFFF) ds = 64'h1_FFFF_FFFF;
    il = ((5 * longint'(alpha) - 4 * ONE_L) * longint'(gamma_q)) >>> 16;
    if (il > 64'sd2147483647) il = 64'sd2147483647;
    if (il < -64'sd2147483648) il = -64'sd2147483648;
    r.delta            = dl[31:0];
    r.heaviside        = 17'(h);
    r.heaviside_scaled = 17'(hs);
    r.delta_scale      = ds[32:0];
    r.initial_level    = 32'(il);
    r.liquid_flag      = alpha >= 17'(ALPHA_LIQUID);
    return r;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int idle_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // send one cell request and log its expected result on acceptance;
  // valid stays up after the accepting edge so the next call can follow
  // without a gap, and drain_pipeline drops it
  task automatic send_cell(logic [31:0] psi, logic [16:0] alpha);
    int gap;
    gap = idle_gap();
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {7'd0, alpha, psi};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_cell(psi, alpha));
    cells_sent++;
    if ($signed(psi) <= $signed({1'b0, eps_q[30:0]}) &&
        $signed(psi) >= -$signed({1'b0, eps_q[30:0]})) band_cells++;
  endtask

  // drop valid, then hold off until every result is back and the pipeline is empty
  task automatic drain_pipeline();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_EPSILON:     eps_q   = 64'(value[30:0]);
      REG_INV_EPSILON: inv_q   = 64'(value);
      REG_GAMMA:       gamma_q = 64'(value[30:0]);
      default: ;
    endcase
  endtask

  task automatic apply_config(logic [31:0] eps, logic [31:0] inv, logic [31:0] gam);
    drain_pipeline();
    write_reg(REG_EPSILON, eps);
    write_reg(REG_INV_EPSILON, inv);
    write_reg(REG_GAMMA, gam);
    config_sets++;
  endtask

  // psi mostly inside the band, the rest anywhere
  function automatic logic [31:0] pick_psi();
    longint e;
    e = longint'(eps_q);
    if ($urandom_range(0, 9) < 7) return 32'($urandom_range(0, 32'(2 * e)) - e);
    return $urandom();
  endfunction

  function automatic logic [16:0] pick_alpha();
    if ($urandom_range(0, 9) < 8) return 17'($urandom_range(0, 65536));
    return 17'($urandom());
  endfunction

  // reset registers: band edges, zero, extremes of psi and alpha
  task automatic test_directed();
    send_cell(32'd0, 17'd0);
    send_cell(32'd65536, 17'd65536);
    send_cell(-32'sd65536, 17'd52429);
    send_cell(32'd65537, 17'd52428);
    send_cell(-32'sd65537, 17'h1FFFF);
    send_cell(32'h7FFF_FFFF, 17'd32768);
    send_cell(32'h8000_0000, 17'd65535);
    send_cell(32'd32768, 17'd1);
    send_cell(-32'sd32768, 17'd39322);
    send_cell(32'd16384, 17'd100000);
    send_cell(-32'sd1, 17'd65536);
    send_cell(32'd1, 17'd0);
    // wait for every result before going on
    drain_pipeline();
  endtask

  // corner register values, including inexact reciprocals and saturation
  task automatic test_register_extremes();
    apply_config(32'd1, 32'hFFFF_FFFF, 32'd0);
    send_cell(32'd0, 17'd0);
    send_cell(32'd1, 17'h1FFFF);
    send_cell(-32'sd1, 17'd65536);
    send_cell(32'd2, 17'd52429);
    apply_config(32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF);
    send_cell(32'h7FFF_FFFF, 17'd0);
    send_cell(32'h8000_0000, 17'h1FFFF);
    send_cell(-32'sd2147483647, 17'd65536);
    send_cell(32'd0, 17'd52428);
    apply_config(32'd65536, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_cell(32'd65536, 17'd0);
    send_cell(-32'sd20000, 17'h1FFFF);
  endtask

  // random cells under a series of register settings
  task automatic test_random_sweep();
    logic [31:0] cfg_eps [6] = '{32'd65536, 32'd98304, 32'd32768, 32'd262144,
                                 32'd1, 32'h7FFF_FFFF};
    logic [31:0] cfg_inv [6] = '{32'd65536, 32'd43691, 32'd131072, 32'd16384,
                                 32'hFFFF_FFFF, 32'd1};
    logic [31:0] cfg_gam [6] = '{32'd49152, 32'd73728, 32'd24576, 32'h7FFF_FFFF,
                                 32'd0, 32'd196608};
    for (int c = 0; c < 6; c++) begin
      apply_config(cfg_eps[c], cfg_inv[c], cfg_gam[c]);
      for (int i = 0; i < 70; i++) begin
        steady = (i >= 20 && i < 35);
        send_cell(pick_psi(), pick_alpha());
      end
      steady = 1'b0;
    end
  endtask

  // random result-side backpressure, with steady stretches
  always @(negedge clk_i) begin
    if (steady || !rst_ni) m_axis_tready <= 1'b1;
    else m_axis_tready <= (idle_gap() == 0);
  end

  // compare each returned result with the oldest prediction
  always @(posedge clk_i) begin
    cell_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[131:0];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got.delta !== want.delta) begin
          $display("%0t: delta exp %h got %h", $time, want.delta, got.delta);
          errors++;
        end
        if (got.heaviside !== want.heaviside) begin
          $display("%0t: heaviside exp %h got %h", $time, want.heaviside, got.heaviside);
          errors++;
        end
        if (got.heaviside_scaled !== want.heaviside_scaled) begin
          $display("%0t: heaviside_scaled exp %h got %h", $time,
                   want.heaviside_scaled, got.heaviside_scaled);
          errors++;
        end
        if (got.delta_scale !== want.delta_scale) begin
          $display("%0t: delta_scale exp %h got %h", $time, want.delta_scale,
                   got.delta_scale);
          errors++;
        end
        if (got.initial_level !== want.initial_level) begin
          $display("%0t: initial_level exp %h got %h", $time, want.initial_level,
                   got.initial_level);
          errors++;
        end
        if (got.liquid_flag !== want.liquid_flag) begin
          $display("%0t: liquid_flag exp %b got %b", $time, want.liquid_flag,
                   got.liquid_flag);
          errors++;
        end
      end
    end
  end

  initial begin
    fill_sine_table();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_register_extremes();
    test_random_sweep();
    drain_pipeline();
    $display("Run covered %0d cells (%0d inside the band) over %0d register sets;",
             cells_sent, band_cells, config_sets + 1);
    $display("%0d results checked, %0d mismatches.", results_checked, errors);
    if (errors == 0) $display("** level_set_smoothed_heaviside: PASSED **");
    else $display("** level_set_smoothed_heaviside: FAILED **");
    $finish;
  end

  // watchdog on a hung handshake
  initial begin
    #5ms;
    $display("** level_set_smoothed_heaviside: FAILED **");
    $finish;
  end

endmodule
